FILE: rtl/obb_pkg.sv
`timescale 1ns / 1ps

package obb_pkg;

    typedef enum logic [1:0] {
        OP_NEW     = 2'd0,
        OP_CANCEL  = 2'd1,
        OP_TRADE   = 2'd2,
        OP_UNKNOWN = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        KIND_HEAD = 2'd0,
        KIND_BID  = 2'd1,
        KIND_ASK  = 2'd2,
        KIND_NONE = 2'd3
    } kind_t;

    localparam logic [10:0] ORDERS_MAX = 11'd2047;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_FIND,
        S_APPLY,
        S_MUL,
        S_STAT,
        S_BID,
        S_ASK,
        S_HEAD,
        S_LEVEL,
        S_EMIT,
        S_LAST
    } state_t;

    typedef struct packed {
        logic [3:0]  channel;
        logic [31:0] seq_number;
        logic        carries_message;
        logic [1:0]  opcode;
        logic [2:0]  symbol_index;
        logic [31:0] order_key;
        logic        buy_sell;
        logic [31:0] price_in;
        logic [31:0] quantity_in;
        logic [31:0] bid_key;
        logic [31:0] ask_key;
        logic [63:0] event_time;
    } in_item_t;

    typedef struct packed {
        logic [63:0] snap_time;
        logic [2:0]  snap_symbol;
        logic [1:0]  record_kind;
        logic [31:0] level_price;
        logic [63:0] level_quantity;
        logic [10:0] level_orders;
        logic [63:0] total_volume;
        logic [63:0] total_turnover;
        logic [31:0] high_mark;
        logic [31:0] low_mark;
        logic [31:0] last_trade_price;
        logic        final_record;
    } out_item_t;

    typedef struct packed {
        logic        valid;
        logic [2:0]  symbol;
        logic [31:0] key;
        logic        side;
        logic [31:0] price;
        logic [31:0] quantity;
    } entry_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] price;
        logic [63:0] quantity;
        logic [10:0] orders;
    } pend_t;

endpackage

FILE: rtl/obb_ram.sv
`timescale 1ns / 1ps

module obb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/order_book_builder.sv
`timescale 1ns / 1ps

// order book builder: one shared table of ORDER_SLOTS orders in a single-port-read ram, swept
// one slot a cycle by a small sequencer. after reset a clearing pass over all slots runs with
// busy high. a message takes one table pass plus, when it applies, an update (apply; for a trade
// mul, stat, bid, ask); with snapshots on, every bid or ask level costs one more pass, and each
// side ends with a pass that finds nothing unless DEPTH_LEVELS levels were found. stale packets
// and packets with no message, a bad symbol or an unknown opcode are dropped while idle. busy is
// high while an item is worked on; the final record comes out once busy is low again. records
// come out one per strobe cycle and must be taken as they appear, since the receiver cannot stall the block
module order_book_builder #(
    parameter int NUM_CHANNELS = 16,
    parameter int NUM_SYMBOLS  = 8,
    parameter int ORDER_SLOTS  = 1024,
    parameter int DEPTH_LEVELS = 10
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  obb_pkg::in_item_t   item,
    input  logic                cfg_we,
    input  logic                cfg_wdata,
    output logic                record_strobe,
    output obb_pkg::out_item_t  record
);

    localparam int CH_W   = NUM_CHANNELS > 1 ? $clog2(NUM_CHANNELS) : 1;
    localparam int SYM_W  = NUM_SYMBOLS > 1 ? $clog2(NUM_SYMBOLS) : 1;
    localparam int SLOT_W = ORDER_SLOTS > 1 ? $clog2(ORDER_SLOTS) : 1;
    localparam int LV_W   = $clog2(DEPTH_LEVELS + 1);
    localparam int ENT_W  = $bits(obb_pkg::entry_t);
    localparam logic [SLOT_W:0] SLOTS_END = (SLOT_W + 1)'(ORDER_SLOTS);
    localparam logic [LV_W-1:0] LV_LAST   = LV_W'(DEPTH_LEVELS - 1);

    obb_pkg::state_t state_reg, state_next;

    // sequence tracking and symbol statistics
    logic        ch_seen_reg [NUM_CHANNELS];
    logic [31:0] ch_seq_reg  [NUM_CHANNELS];
    logic [63:0] vol_reg     [NUM_SYMBOLS];
    logic [63:0] turn_reg    [NUM_SYMBOLS];
    logic [31:0] high_reg    [NUM_SYMBOLS];
    logic [31:0] low_reg     [NUM_SYMBOLS];
    logic [31:0] last_reg    [NUM_SYMBOLS];

    logic snap_en_reg;

    obb_pkg::in_item_t item_reg, item_next;

    logic [SLOT_W:0]   scan_idx_reg, scan_idx_next;
    logic              d_vld_reg, d_vld_next;
    logic [SLOT_W-1:0] d_idx_reg, d_idx_next;

    logic              k_found_reg, k_found_next;
    logic [SLOT_W-1:0] k_slot_reg, k_slot_next;
    logic              f_found_reg, f_found_next;
    logic [SLOT_W-1:0] f_slot_reg, f_slot_next;
    logic              b_found_reg, b_found_next;
    logic [SLOT_W-1:0] b_slot_reg, b_slot_next;
    obb_pkg::entry_t   b_ent_reg, b_ent_next;
    logic              a_found_reg, a_found_next;
    logic [SLOT_W-1:0] a_slot_reg, a_slot_next;
    obb_pkg::entry_t   a_ent_reg, a_ent_next;
    logic [63:0]       prod_reg, prod_next;

    logic              side_reg, side_next;
    logic [LV_W-1:0]   lv_reg, lv_next;
    logic              lf_reg, lf_next;
    logic [31:0]       best_reg, best_next;
    logic [63:0]       sum_reg, sum_next;
    logic [10:0]       cnt_reg, cnt_next;
    logic [31:0]       prev_reg, prev_next;
    obb_pkg::pend_t    pend_reg, pend_next;

    logic               rec_strobe_reg;
    obb_pkg::out_item_t rec_reg;
    logic               emit_now, emit_final;

    logic              ram_we;
    logic [SLOT_W-1:0] ram_waddr;
    obb_pkg::entry_t   ram_wentry;
    logic [ENT_W-1:0]  ram_rdata;
    obb_pkg::entry_t   e;

    logic              ch_wr;
    logic [CH_W-1:0]   ch_i;
    logic [SYM_W-1:0]  sym_i;
    logic              sym_wr;
    logic              ch_ok, fresh, sym_ok;
    logic              hit, scan_done, lv_match;
    obb_pkg::entry_t   red_ent;
    logic [31:0]       tp;

    obb_ram #(
        .WIDTH(ENT_W),
        .DEPTH(ORDER_SLOTS)
    ) u_table (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wentry),
        .raddr(scan_idx_reg[SLOT_W-1:0]),
        .rdata(ram_rdata)
    );

    assign e         = obb_pkg::entry_t'(ram_rdata);
    assign busy      = (state_reg != obb_pkg::S_IDLE);
    assign ch_i      = CH_W'(item.channel);
    assign sym_i     = SYM_W'(item_reg.symbol_index);
    assign ch_ok     = (32'(item.channel) < NUM_CHANNELS);
    assign fresh     = ch_ok && (!ch_seen_reg[ch_i] || (item.seq_number > ch_seq_reg[ch_i]));
    assign sym_ok    = (32'(item.symbol_index) < NUM_SYMBOLS);
    assign hit       = d_vld_reg && e.valid && (e.symbol == item_reg.symbol_index);
    assign scan_done = (scan_idx_reg == SLOTS_END) && !d_vld_reg;
    assign tp        = item_reg.price_in;

    // level filter: strictly past the previous level in the side's order
    always_comb
    begin
        lv_match = hit && (e.side == side_reg);
        if (lv_reg != '0)
        begin
            if (side_reg)
            begin
                lv_match = lv_match && (e.price > prev_reg);
            end
            else
            begin
                lv_match = lv_match && (e.price < prev_reg);
            end
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        item_next     = item_reg;
        scan_idx_next = scan_idx_reg;
        d_vld_next    = 1'b0;
        d_idx_next    = d_idx_reg;
        k_found_next  = k_found_reg;
        k_slot_next   = k_slot_reg;
        f_found_next  = f_found_reg;
        f_slot_next   = f_slot_reg;
        b_found_next  = b_found_reg;
        b_slot_next   = b_slot_reg;
        b_ent_next    = b_ent_reg;
        a_found_next  = a_found_reg;
        a_slot_next   = a_slot_reg;
        a_ent_next    = a_ent_reg;
        prod_next     = prod_reg;
        side_next     = side_reg;
        lv_next       = lv_reg;
        lf_next       = lf_reg;
        best_next     = best_reg;
        sum_next      = sum_reg;
        cnt_next      = cnt_reg;
        prev_next     = prev_reg;
        pend_next     = pend_reg;
        emit_now      = 1'b0;
        emit_final    = 1'b0;
        ram_we        = 1'b0;
        ram_waddr     = scan_idx_reg[SLOT_W-1:0];
        ram_wentry    = '0;
        ch_wr         = 1'b0;
        sym_wr        = 1'b0;
        red_ent       = b_ent_reg;

        if ((state_reg == obb_pkg::S_FIND || state_reg == obb_pkg::S_LEVEL)
            && scan_idx_reg != SLOTS_END)
        begin
            d_vld_next    = 1'b1;
            d_idx_next    = scan_idx_reg[SLOT_W-1:0];
            scan_idx_next = scan_idx_reg + 1'b1;
        end

        case (state_reg)
            obb_pkg::S_CLEAR:
            begin
                ram_we = 1'b1;
                if (scan_idx_reg == SLOTS_END - 1'b1)
                begin
                    state_next = obb_pkg::S_IDLE;
                end
                scan_idx_next = scan_idx_reg + 1'b1;
            end
            obb_pkg::S_IDLE:
            begin
                if (start)
                begin
                    item_next     = item;
                    ch_wr         = fresh;
                    scan_idx_next = '0;
                    k_found_next  = 1'b0;
                    f_found_next  = 1'b0;
                    b_found_next  = 1'b0;
                    a_found_next  = 1'b0;
                    if (fresh && item.carries_message && sym_ok
                        && item.opcode != obb_pkg::OP_UNKNOWN)
                    begin
                        state_next = obb_pkg::S_FIND;
                    end
                end
            end
            obb_pkg::S_FIND:
            begin
                if (hit && e.key == item_reg.order_key && !k_found_reg)
                begin
                    k_found_next = 1'b1;
                    k_slot_next  = d_idx_reg;
                end
                if (d_vld_reg && !e.valid && !f_found_reg)
                begin
                    f_found_next = 1'b1;
                    f_slot_next  = d_idx_reg;
                end
                if (hit && e.key == item_reg.bid_key && !b_found_reg)
                begin
                    b_found_next = 1'b1;
                    b_slot_next  = d_idx_reg;
                    b_ent_next   = e;
                end
                if (hit && e.key == item_reg.ask_key && !a_found_reg)
                begin
                    a_found_next = 1'b1;
                    a_slot_next  = d_idx_reg;
                    a_ent_next   = e;
                end
                if (scan_done)
                begin
                    if (item_reg.opcode == obb_pkg::OP_TRADE)
                    begin
                        state_next = (b_found_reg || a_found_reg) ? obb_pkg::S_MUL
                                                                  : obb_pkg::S_IDLE;
                    end
                    else if (item_reg.opcode == obb_pkg::OP_NEW)
                    begin
                        state_next = (k_found_reg || f_found_reg) ? obb_pkg::S_APPLY
                                                                  : obb_pkg::S_IDLE;
                    end
                    else
                    begin
                        state_next = k_found_reg ? obb_pkg::S_APPLY : obb_pkg::S_IDLE;
                    end
                end
            end
            obb_pkg::S_APPLY:
            begin
                ram_we    = 1'b1;
                ram_waddr = k_found_reg ? k_slot_reg : f_slot_reg;
                if (item_reg.opcode == obb_pkg::OP_NEW)
                begin
                    ram_wentry.valid    = 1'b1;
                    ram_wentry.symbol   = item_reg.symbol_index;
                    ram_wentry.key      = item_reg.order_key;
                    ram_wentry.side     = item_reg.buy_sell;
                    ram_wentry.price    = item_reg.price_in;
                    ram_wentry.quantity = item_reg.quantity_in;
                end
                state_next = snap_en_reg ? obb_pkg::S_HEAD : obb_pkg::S_IDLE;
            end
            obb_pkg::S_MUL:
            begin
                prod_next  = 64'(tp) * 64'(item_reg.quantity_in);
                state_next = obb_pkg::S_STAT;
            end
            obb_pkg::S_STAT:
            begin
                sym_wr     = 1'b1;
                state_next = obb_pkg::S_BID;
            end
            obb_pkg::S_BID:
            begin
                red_ent = b_ent_reg;
                if (item_reg.quantity_in >= b_ent_reg.quantity)
                begin
                    red_ent.valid = 1'b0;
                end
                else
                begin
                    red_ent.quantity = b_ent_reg.quantity - item_reg.quantity_in;
                end
                ram_we     = b_found_reg;
                ram_waddr  = b_slot_reg;
                ram_wentry = red_ent;
                // same order on both sides: the ask sees what the bid left
                if (b_found_reg && a_found_reg && a_slot_reg == b_slot_reg)
                begin
                    a_ent_next = red_ent;
                end
                state_next = obb_pkg::S_ASK;
            end
            obb_pkg::S_ASK:
            begin
                red_ent = a_ent_reg;
                if (item_reg.quantity_in >= a_ent_reg.quantity)
                begin
                    red_ent.valid = 1'b0;
                end
                else
                begin
                    red_ent.quantity = a_ent_reg.quantity - item_reg.quantity_in;
                end
                ram_we     = a_found_reg && a_ent_reg.valid;
                ram_waddr  = a_slot_reg;
                ram_wentry = red_ent;
                state_next = snap_en_reg ? obb_pkg::S_HEAD : obb_pkg::S_IDLE;
            end
            obb_pkg::S_HEAD:
            begin
                pend_next     = '{kind: obb_pkg::KIND_HEAD, price: '0, quantity: '0, orders: '0};
                side_next     = 1'b0;
                lv_next       = '0;
                lf_next       = 1'b0;
                scan_idx_next = '0;
                state_next    = obb_pkg::S_LEVEL;
            end
            obb_pkg::S_LEVEL:
            begin
                if (lv_match)
                begin
                    if (!lf_reg || (side_reg ? (e.price < best_reg) : (e.price > best_reg)))
                    begin
                        lf_next   = 1'b1;
                        best_next = e.price;
                        sum_next  = 64'(e.quantity);
                        cnt_next  = 11'd1;
                    end
                    else if (e.price == best_reg)
                    begin
                        sum_next = sum_reg + 64'(e.quantity);
                        if (cnt_reg != obb_pkg::ORDERS_MAX)
                        begin
                            cnt_next = cnt_reg + 11'd1;
                        end
                    end
                end
                if (scan_done)
                begin
                    state_next = obb_pkg::S_EMIT;
                end
            end
            obb_pkg::S_EMIT:
            begin
                scan_idx_next = '0;
                lf_next       = 1'b0;
                state_next    = obb_pkg::S_LEVEL;
                if (lf_reg)
                begin
                    emit_now  = 1'b1;
                    pend_next = '{kind: (side_reg ? obb_pkg::KIND_ASK : obb_pkg::KIND_BID),
                                  price: best_reg, quantity: sum_reg, orders: cnt_reg};
                    prev_next = best_reg;
                    lv_next   = lv_reg + 1'b1;
                end
                if (!lf_reg || lv_reg == LV_LAST)
                begin
                    if (!side_reg)
                    begin
                        side_next = 1'b1;
                        lv_next   = '0;
                    end
                    else
                    begin
                        state_next = obb_pkg::S_LAST;
                    end
                end
            end
            obb_pkg::S_LAST:
            begin
                emit_now   = 1'b1;
                emit_final = 1'b1;
                state_next = obb_pkg::S_IDLE;
            end
            default:
            begin
                state_next = obb_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= obb_pkg::S_CLEAR;
            scan_idx_reg   <= '0;
            d_vld_reg      <= 1'b0;
            snap_en_reg    <= 1'b1;
            rec_strobe_reg <= 1'b0;
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                ch_seen_reg[i] <= 1'b0;
                ch_seq_reg[i]  <= '0;
            end
            for (int i = 0; i < NUM_SYMBOLS; i++)
            begin
                vol_reg[i]  <= '0;
                turn_reg[i] <= '0;
                high_reg[i] <= '0;
                low_reg[i]  <= '0;
                last_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg      <= state_next;
            scan_idx_reg   <= scan_idx_next;
            d_vld_reg      <= d_vld_next;
            rec_strobe_reg <= emit_now;
            if (cfg_we)
            begin
                snap_en_reg <= cfg_wdata;
            end
            if (ch_wr)
            begin
                ch_seen_reg[ch_i] <= 1'b1;
                ch_seq_reg[ch_i]  <= item.seq_number;
            end
            if (sym_wr)
            begin
                vol_reg[sym_i]  <= vol_reg[sym_i] + 64'(item_reg.quantity_in);
                turn_reg[sym_i] <= turn_reg[sym_i] + prod_reg;
                // zero means no trade yet
                if (high_reg[sym_i] == '0 || tp > high_reg[sym_i])
                begin
                    high_reg[sym_i] <= tp;
                end
                if (low_reg[sym_i] == '0 || tp < low_reg[sym_i])
                begin
                    low_reg[sym_i] <= tp;
                end
                last_reg[sym_i] <= tp;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg    <= item_next;
        d_idx_reg   <= d_idx_next;
        k_found_reg <= k_found_next;
        k_slot_reg  <= k_slot_next;
        f_found_reg <= f_found_next;
        f_slot_reg  <= f_slot_next;
        b_found_reg <= b_found_next;
        b_slot_reg  <= b_slot_next;
        b_ent_reg   <= b_ent_next;
        a_found_reg <= a_found_next;
        a_slot_reg  <= a_slot_next;
        a_ent_reg   <= a_ent_next;
        prod_reg    <= prod_next;
        side_reg    <= side_next;
        lv_reg      <= lv_next;
        lf_reg      <= lf_next;
        best_reg    <= best_next;
        sum_reg     <= sum_next;
        cnt_reg     <= cnt_next;
        prev_reg    <= prev_next;
        pend_reg    <= pend_next;
        if (emit_now)
        begin
            rec_reg.snap_time        <= item_reg.event_time;
            rec_reg.snap_symbol      <= item_reg.symbol_index;
            rec_reg.record_kind      <= pend_reg.kind;
            rec_reg.level_price      <= pend_reg.price;
            rec_reg.level_quantity   <= pend_reg.quantity;
            rec_reg.level_orders     <= pend_reg.orders;
            rec_reg.total_volume     <= vol_reg[sym_i];
            rec_reg.total_turnover   <= turn_reg[sym_i];
            rec_reg.high_mark        <= high_reg[sym_i];
            rec_reg.low_mark         <= low_reg[sym_i];
            rec_reg.last_trade_price <= last_reg[sym_i];
            rec_reg.final_record     <= emit_final;
        end
    end

    assign record_strobe = rec_strobe_reg;
    assign record        = rec_reg;

`ifndef ASSERT_OFF
    a_strobe_src: assert property (@(posedge clk) disable iff (!rst_n)
        record_strobe |-> ($past(state_reg) == obb_pkg::S_EMIT
                           || $past(state_reg) == obb_pkg::S_LAST))
        else $error("record strobe without an emitting step");

    a_final_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (record_strobe && record.final_record) |=> !record_strobe)
        else $error("record straight after the final record");

    a_lv_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == obb_pkg::S_LEVEL) |-> (lv_reg < LV_W'(DEPTH_LEVELS)))
        else $error("level counter past depth");

    a_no_write_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == obb_pkg::S_FIND || state_reg == obb_pkg::S_LEVEL) |-> !ram_we)
        else $error("table written during a scan");
`endif

endmodule

FILE: tb/order_book_builder_tb.sv
`timescale 1ns / 1ps

module order_book_builder_tb;
    import obb_pkg::*;

    localparam int SLOTS = 1024;
    localparam int LEVELS = 10;
    localparam longint CYCLE_LIMIT = 64'd30_000_000;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    in_item_t item;
    logic cfg_we;
    logic cfg_wdata;
    logic record_strobe;
    out_item_t record;

    order_book_builder DUT (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .item(item),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata),
        .record_strobe(record_strobe),
        .record(record)
    );

    // book state kept by the testbench
    logic        snap_on;
    logic        ch_seen [16];
    logic [31:0] ch_last [16];
    logic        ord_valid [SLOTS];
    logic [2:0]  ord_sym [SLOTS];
    logic [31:0] ord_key [SLOTS];
    logic        ord_side [SLOTS];
    logic [31:0] ord_price [SLOTS];
    logic [31:0] ord_qty [SLOTS];
    logic [63:0] st_volume [8];
    logic [63:0] st_turnover [8];
    logic [31:0] st_high [8];
    logic [31:0] st_low [8];
    logic [31:0] st_last [8];

    out_item_t expected_records[$];
    int errors;
    int gap_pct;
    longint cycles;
    logic [31:0] tx_seq [16];

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic report(input string what);
        errors++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    function automatic int find_order(input logic [2:0] sym, input logic [31:0] key);
        for (int i = 0; i < SLOTS; i++)
            if (ord_valid[i] && ord_sym[i] == sym && ord_key[i] == key)
                return i;
        return -1;
    endfunction

    function automatic void reduce_order(input int slot, input logic [31:0] qty);
        if (slot < 0 || !ord_valid[slot])
            return;
        if (qty >= ord_qty[slot])
            ord_valid[slot] = 1'b0;
        else
            ord_qty[slot] = ord_qty[slot] - qty;
    endfunction

    function automatic bit apply_message(input in_item_t it);
        int slot;
        int b;
        int a;
        logic [2:0] s;
        s = it.symbol_index;
        case (opcode_t'(it.opcode))
            OP_NEW: begin
                slot = find_order(s, it.order_key);
                if (slot < 0) begin
                    for (int i = 0; i < SLOTS; i++)
                        if (!ord_valid[i]) begin
                            slot = i;
                            break;
                        end
                    if (slot < 0)
                        return 0;
                end
                ord_valid[slot] = 1'b1;
                ord_sym[slot] = s;
                ord_key[slot] = it.order_key;
                ord_side[slot] = it.buy_sell;
                ord_price[slot] = it.price_in;
                ord_qty[slot] = it.quantity_in;
                return 1;
            end
            OP_CANCEL: begin
                slot = find_order(s, it.order_key);
                if (slot < 0)
                    return 0;
                ord_valid[slot] = 1'b0;
                return 1;
            end
            OP_TRADE: begin
                b = find_order(s, it.bid_key);
                a = find_order(s, it.ask_key);
                if (b < 0 && a < 0)
                    return 0;
                st_volume[s] = st_volume[s] + 64'(it.quantity_in);
                st_turnover[s] = st_turnover[s] + 64'(it.price_in) * 64'(it.quantity_in);
                if (st_high[s] == 0 || it.price_in > st_high[s])
                    st_high[s] = it.price_in;
                if (st_low[s] == 0 || it.price_in < st_low[s])
                    st_low[s] = it.price_in;
                st_last[s] = it.price_in;
                reduce_order(b, it.quantity_in);
                reduce_order(a, it.quantity_in);
                return 1;
            end
            default: return 0;
        endcase
    endfunction

    function automatic out_item_t make_record(input in_item_t it, input kind_t kind,
                                              input logic [31:0] price,
                                              input logic [63:0] qty, input int cnt);
        out_item_t r;
        logic [2:0] s;
        s = it.symbol_index;
        r.snap_time = it.event_time;
        r.snap_symbol = s;
        r.record_kind = kind;
        r.level_price = price;
        r.level_quantity = qty;
        r.level_orders = cnt > 2047 ? ORDERS_MAX : 11'(cnt);
        r.total_volume = st_volume[s];
        r.total_turnover = st_turnover[s];
        r.high_mark = st_high[s];
        r.low_mark = st_low[s];
        r.last_trade_price = st_last[s];
        r.final_record = 1'b0;
        return r;
    endfunction

    // aggregated levels of one side: bids best first descending, asks ascending
    function automatic void add_levels(input in_item_t it, input logic side);
        logic [31:0] prev;
        logic [31:0] best;
        logic [63:0] sum;
        int cnt;
        bit found;
        prev = '0;
        for (int lv = 0; lv < LEVELS; lv++) begin
            found = 0;
            best = '0;
            for (int i = 0; i < SLOTS; i++) begin
                if (!ord_valid[i] || ord_sym[i] != it.symbol_index || ord_side[i] != side)
                    continue;
                if (lv > 0 && (side == 1'b0 ? ord_price[i] >= prev : ord_price[i] <= prev))
                    continue;
                if (!found || (side == 1'b0 ? ord_price[i] > best : ord_price[i] < best)) begin
                    best = ord_price[i];
                    found = 1;
                end
            end
            if (!found)
                break;
            sum = '0;
            cnt = 0;
            for (int i = 0; i < SLOTS; i++)
                if (ord_valid[i] && ord_sym[i] == it.symbol_index && ord_side[i] == side
                    && ord_price[i] == best) begin
                    sum = sum + 64'(ord_qty[i]);
                    cnt++;
                end
            expected_records.push_back(make_record(it, side ? KIND_ASK : KIND_BID,
                                                   best, sum, cnt));
            prev = best;
        end
    endfunction

    function automatic void predict_book(input in_item_t it);
        out_item_t last;
        if (ch_seen[it.channel] && it.seq_number <= ch_last[it.channel])
            return;
        ch_seen[it.channel] = 1'b1;
        ch_last[it.channel] = it.seq_number;
        if (!it.carries_message)
            return;
        if (!apply_message(it))
            return;
        if (!snap_on)
            return;
        expected_records.push_back(make_record(it, KIND_HEAD, '0, '0, 0));
        add_levels(it, 1'b0);
        add_levels(it, 1'b1);
        last = expected_records.pop_back();
        last.final_record = 1'b1;
        expected_records.push_back(last);
    endfunction

    always @(posedge clk) begin
        out_item_t want;
        if (rst_n && record_strobe) begin
            if (expected_records.size() == 0) begin
                report($sformatf("record with none expected, kind %0d", record.record_kind));
            end else begin
                want = expected_records.pop_front();
                if (record.snap_time !== want.snap_time)
                    report($sformatf("snap_time %h want %h", record.snap_time, want.snap_time));
                if (record.snap_symbol !== want.snap_symbol)
                    report($sformatf("snap_symbol %0d want %0d", record.snap_symbol,
                                     want.snap_symbol));
                if (record.record_kind !== want.record_kind)
                    report($sformatf("record_kind %0d want %0d", record.record_kind,
                                     want.record_kind));
                if (record.level_price !== want.level_price)
                    report($sformatf("level_price %h want %h", record.level_price,
                                     want.level_price));
                if (record.level_quantity !== want.level_quantity)
                    report($sformatf("level_quantity %h want %h", record.level_quantity,
                                     want.level_quantity));
                if (record.level_orders !== want.level_orders)
                    report($sformatf("level_orders %0d want %0d", record.level_orders,
                                     want.level_orders));
                if (record.total_volume !== want.total_volume)
                    report($sformatf("total_volume %h want %h", record.total_volume,
                                     want.total_volume));
                if (record.total_turnover !== want.total_turnover)
                    report($sformatf("total_turnover %h want %h", record.total_turnover,
                                     want.total_turnover));
                if (record.high_mark !== want.high_mark)
                    report($sformatf("high_mark %h want %h", record.high_mark, want.high_mark));
                if (record.low_mark !== want.low_mark)
                    report($sformatf("low_mark %h want %h", record.low_mark, want.low_mark));
                if (record.last_trade_price !== want.last_trade_price)
                    report($sformatf("last_trade_price %h want %h", record.last_trade_price,
                                     want.last_trade_price));
                if (record.final_record !== want.final_record)
                    report($sformatf("final_record %0d want %0d", record.final_record,
                                     want.final_record));
            end
        end
    end

    task automatic send_item(input in_item_t it);
        int gap;
        if (gap_pct > 0) begin
            while ($urandom_range(99) < gap_pct) begin
                gap = $urandom_range(12, 1);
                repeat (gap) @(negedge clk);
            end
        end
        item = it;
        start = 1'b1;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        predict_book(it);
        @(negedge clk);
        start = 1'b0;
    endtask

    task automatic drain();
        while (expected_records.size() != 0)
            @(posedge clk);
        @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_snapshot_enable(input logic value);
        drain();
        cfg_we = 1'b1;
        cfg_wdata = value;
        @(negedge clk);
        cfg_we = 1'b0;
        snap_on = value;
    endtask

    function automatic in_item_t msg(input logic [3:0] ch, input opcode_t op,
                                     input logic [2:0] sym, input logic [31:0] key,
                                     input logic side, input logic [31:0] price,
                                     input logic [31:0] qty);
        in_item_t it;
        it.channel = ch;
        tx_seq[ch] = tx_seq[ch] + $urandom_range(200, 1);
        it.seq_number = tx_seq[ch];
        it.carries_message = 1'b1;
        it.opcode = op;
        it.symbol_index = sym;
        it.order_key = key;
        it.buy_sell = side;
        it.price_in = price;
        it.quantity_in = qty;
        it.bid_key = $urandom;
        it.ask_key = $urandom;
        it.event_time = {$urandom, $urandom};
        return it;
    endfunction

    function automatic in_item_t trade(input logic [3:0] ch, input logic [2:0] sym,
                                       input logic [31:0] bk, input logic [31:0] ak,
                                       input logic [31:0] price, input logic [31:0] qty);
        in_item_t it;
        it = msg(ch, OP_TRADE, sym, $urandom, $urandom_range(1), price, qty);
        it.bid_key = bk;
        it.ask_key = ak;
        return it;
    endfunction

    task automatic test_directed();
        in_item_t it;
        gap_pct = 0;
        send_item(msg(0, OP_NEW, 0, 32'hFFFF_FFFF, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_item(msg(0, OP_NEW, 0, 32'h0, 1'b1, 32'h0, 32'h0));
        send_item(msg(1, OP_NEW, 0, 32'd5, 1'b0, 32'd100, 32'd40));
        send_item(msg(1, OP_NEW, 0, 32'd6, 1'b0, 32'd100, 32'd60));
        send_item(msg(1, OP_NEW, 0, 32'd7, 1'b1, 32'd120, 32'd30));
        // overwrite of an existing key, side and price move
        send_item(msg(2, OP_NEW, 0, 32'd6, 1'b1, 32'd110, 32'd25));
        // partial fill on both sides
        send_item(trade(2, 0, 32'd5, 32'd7, 32'd110, 32'd10));
        // one side present only, other key absent
        send_item(trade(3, 0, 32'd5, 32'h1234_5678, 32'd90, 32'd100));
        // neither present: rejected
        send_item(trade(3, 0, 32'hDEAD_0001, 32'hDEAD_0002, 32'd95, 32'd1));
        // same key on both sides
        send_item(trade(4, 0, 32'd7, 32'd7, 32'd105, 32'd10));
        // trade at price zero, then at the extremes so that the sums wrap
        send_item(msg(4, OP_NEW, 1, 32'd1, 1'b0, 32'd50, 32'hFFFF_FFFF));
        send_item(trade(4, 1, 32'd1, 32'd1, 32'd0, 32'd1));
        send_item(trade(5, 1, 32'd1, 32'd9, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_item(msg(5, OP_NEW, 1, 32'd2, 1'b1, 32'd60, 32'd3));
        send_item(trade(5, 1, 32'd3, 32'd2, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_item(msg(6, OP_CANCEL, 0, 32'hFFFF_FFFF, 1'b0, 32'd0, 32'd0));
        send_item(msg(6, OP_CANCEL, 0, 32'hAAAA_5555, 1'b0, 32'd0, 32'd0));
        send_item(msg(6, OP_UNKNOWN, 7, 32'd0, 1'b0, 32'd1, 32'd1));
        it = msg(7, OP_NEW, 7, 32'd3, 1'b0, 32'd7, 32'd7);
        it.carries_message = 1'b0;
        send_item(it);
        // stale and repeated sequence numbers
        it = msg(7, OP_NEW, 7, 32'd4, 1'b0, 32'd7, 32'd7);
        it.seq_number = tx_seq[7] - 1;
        send_item(it);
        it.seq_number = tx_seq[7];
        send_item(it);
        it = msg(15, OP_NEW, 7, 32'd4, 1'b1, 32'd8, 32'd8);
        it.seq_number = 32'hFFFF_FFFF;
        send_item(it);
        it.seq_number = 32'hFFFF_FFFF;
        it.opcode = OP_CANCEL;
        send_item(it);
    endtask

    task automatic test_table_full();
        int added;
        in_item_t it;
        write_snapshot_enable(1'b0);
        added = 0;
        gap_pct = 0;
        for (int i = 0; i < SLOTS; i++)
            if (!ord_valid[i]) begin
                send_item(msg(8, OP_NEW, 5, 32'h8000_0000 + added, added[0],
                              32'd300 + (added % 3), 32'd1 + added));
                added++;
            end
        write_snapshot_enable(1'b1);
        // absent key with no free slot: dropped
        send_item(msg(8, OP_NEW, 5, 32'h7FFF_FFFF, 1'b0, 32'd1, 32'd1));
        // existing key still accepted while full
        send_item(msg(8, OP_NEW, 5, 32'h8000_0000, 1'b1, 32'd299, 32'd9));
        write_snapshot_enable(1'b0);
        for (int k = 0; k < added; k++)
            send_item(msg(8, OP_CANCEL, 5, 32'h8000_0000 + k, 1'b0, 32'd0, 32'd0));
        write_snapshot_enable(1'b1);
    endtask

    function automatic in_item_t random_item();
        in_item_t it;
        int r;
        logic [2:0] s;
        logic [3:0] ch;
        ch = 4'($urandom_range(14));
        s = 3'($urandom_range(7));
        r = $urandom_range(99);
        if (r < 45)
            it = msg(ch, OP_NEW, s, $urandom_range(15), $urandom_range(1),
                     32'd1000 + $urandom_range(6), $urandom_range(500, 1));
        else if (r < 63)
            it = msg(ch, OP_CANCEL, s, $urandom_range(15), 1'b0, $urandom, $urandom);
        else if (r < 93)
            it = trade(ch, s, $urandom_range(15), $urandom_range(15),
                       32'd1000 + $urandom_range(6), $urandom_range(300, 1));
        else
            it = msg(ch, OP_UNKNOWN, s, $urandom, $urandom_range(1), $urandom, $urandom);
        if ($urandom_range(99) < 5)
            it.order_key = $urandom;
        if ($urandom_range(99) < 3)
            it.price_in = $urandom;
        if ($urandom_range(99) < 4)
            it.carries_message = 1'b0;
        if ($urandom_range(99) < 6)
            it.seq_number = tx_seq[ch] - $urandom_range(3);
        return it;
    endfunction

    task automatic test_random(input int count, input int pct);
        gap_pct = pct;
        for (int n = 0; n < count; n++) begin
            send_item(random_item());
            if (n == count / 2) begin
                // hold off until the block has emitted everything
                while (expected_records.size() != 0)
                    @(posedge clk);
                @(negedge clk);
            end
        end
    endtask

    initial begin
        rst_n = 1'b0;
        start = 1'b0;
        item = '0;
        cfg_we = 1'b0;
        cfg_wdata = 1'b0;
        errors = 0;
        gap_pct = 0;
        cycles = 0;
        snap_on = 1'b1;
        for (int i = 0; i < 16; i++) begin
            ch_seen[i] = 1'b0;
            ch_last[i] = '0;
            tx_seq[i] = '0;
        end
        for (int i = 0; i < SLOTS; i++)
            ord_valid[i] = 1'b0;
        for (int i = 0; i < 8; i++) begin
            st_volume[i] = '0;
            st_turnover[i] = '0;
            st_high[i] = '0;
            st_low[i] = '0;
            st_last[i] = '0;
        end
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_table_full();
        test_random(60, 0);
        test_random(50, 47);
        write_snapshot_enable(1'b0);
        test_random(25, 11);
        write_snapshot_enable(1'b1);
        test_random(60, 11);
        test_random(25, 0);

        drain();
        repeat (50) @(posedge clk);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

FILE: sim.f
rtl/obb_pkg.sv
rtl/obb_ram.sv
rtl/order_book_builder.sv
tb/order_book_builder_tb.sv
